// File: rtl/assert_macros.svh
// Assertion helpers. All of them sample on the rising clock edge and are
// disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed: always");

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/sqlsig_pkg.sv
package sqlsig_pkg;

    // Bytes kept for text matching, counting the byte being processed.
    localparam int HISTORY_BYTES = 33;
    // Widest text signature.
    localparam int SIG_BYTES = 33;
    localparam int CMP_BYTES = (HISTORY_BYTES < SIG_BYTES) ? HISTORY_BYTES : SIG_BYTES;

    localparam int SEEN_W   = 6;
    localparam int MASK_W   = 7;
    localparam int FLAGS_W  = 8;
    localparam int BIN_LEN  = 18;

    typedef logic [8*SIG_BYTES-1:0]     sig_t;
    typedef logic [8*HISTORY_BYTES-1:0] window_t;
    typedef logic [SEEN_W-1:0]          seen_t;
    typedef logic [BIN_LEN-1:0]         bin_prog_t;

    // Text signatures; last character sits in the low byte.
    localparam sig_t SIG_MYSQL  = "You have an error i";
    localparam sig_t SIG_JDBC   = "java.sql.SQLSyntaxErrorException:";
    localparam sig_t SIG_NOSQL  = "BadValue";
    localparam sig_t SIG_PG_S   = "SERROR";
    localparam sig_t SIG_PG_V   = "VERROR";
    localparam sig_t SIG_PG_N   = "or near";
    localparam sig_t SIG_SQLITE = {"SQLITE", "_ERROR:"};

    localparam seen_t LEN_MYSQL  = 6'd19;
    localparam seen_t LEN_JDBC   = 6'd33;
    localparam seen_t LEN_NOSQL  = 6'd8;
    localparam seen_t LEN_PG_S   = 6'd6;
    localparam seen_t LEN_PG_V   = 6'd6;
    localparam seen_t LEN_PG_N   = 6'd7;
    localparam seen_t LEN_SQLITE = 6'd13;

    // Sticky flag positions
    localparam int FLAG_MYSQL  = 0;
    localparam int FLAG_JDBC   = 1;
    localparam int FLAG_NOSQL  = 2;
    localparam int FLAG_PG_S   = 3;
    localparam int FLAG_PG_V   = 4;
    localparam int FLAG_PG_N   = 5;
    localparam int FLAG_BIN    = 6;
    localparam int FLAG_SQLITE = 7;

    typedef enum logic [2:0] {
        RULE_NONE      = 3'd0,
        RULE_MYSQL     = 3'd1,
        RULE_JDBC_TEXT = 3'd2,
        RULE_NOSQL     = 3'd3,
        RULE_PG        = 3'd4,
        RULE_JDBC_BIN  = 3'd5,
        RULE_SQLITE    = 3'd6
    } rule_code_t;

    typedef enum logic [1:0] {
        EL_LIT,
        EL_ANY,
        EL_PRINT
    } bin_elem_t;

    localparam bin_elem_t BIN_KIND [BIN_LEN] = '{
        EL_LIT, EL_LIT, EL_LIT, EL_LIT, EL_ANY, EL_LIT, EL_LIT, EL_LIT, EL_ANY,
        EL_PRINT, EL_LIT, EL_LIT, EL_LIT, EL_LIT, EL_PRINT, EL_LIT, EL_LIT, EL_LIT
    };

    localparam logic [7:0] BIN_VAL [BIN_LEN] = '{
        8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'hff, 8'hff, 8'hea
    };

    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7f;

    // window[8k +: 8] is the k-th newest byte, k = 0 being the current one.
    function automatic logic text_hit(window_t window, sig_t sig, seen_t len,
                                      seen_t seen);
        logic hit;
        hit = (32'(len) <= HISTORY_BYTES) && (seen >= len);
        for (int k = 0; k < CMP_BYTES; k++) begin
            if ((k < 32'(len)) && (window[8*k +: 8] != sig[8*k +: 8]))
            begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    // One step of the binary pattern NFA; bit k means elements 0..k matched.
    function automatic bin_prog_t bin_advance(bin_prog_t prog, logic [7:0] b);
        bin_prog_t prev;
        bin_prog_t nxt;
        logic      printable;
        prev      = {prog[BIN_LEN-2:0], 1'b1};
        printable = (b >= PRINT_LO) && (b < PRINT_HI);
        for (int k = 0; k < BIN_LEN; k++) begin
            unique case (BIN_KIND[k])
                EL_LIT:   nxt[k] = prev[k] && (b == BIN_VAL[k]);
                EL_ANY:   nxt[k] = prev[k];
                EL_PRINT: nxt[k] = printable && (prev[k] || prog[k]);
                default:  nxt[k] = 1'b0;
            endcase
        end
        return nxt;
    endfunction

endpackage

// File: rtl/sql_error_signature_detector.sv
// SQL error signature detector.
// Input channel: one byte of a buffer per item (data_byte, channel, last_byte),
// moved on in_valid high and in_stall low. channel is taken from the first
// byte of each buffer. last_byte closes the buffer.
// Output channel: one item (detected, rule_code) per buffer, moved on
// out_valid high and out_stall low. rule_code is the highest priority enabled
// rule that matched anywhere in the buffer on its channel.
// Config: cfg_write loads cfg_data into the rule enable mask (bit n enables
// rule n+1); write it only while no buffer is in flight.
// Throughput is one byte per cycle while in_stall is low: all signature
// comparators and the binary pattern NFA work in parallel on the input
// register and the byte history. The verdict is loaded into the output
// register as the last byte leaves the input register.
// While out_stall holds a verdict, non-final bytes keep flowing; a final byte
// waits in the input register, which then raises in_stall.
// Reset clears the flags, NFA progress, channel and byte count, and enables every rule.
`include "assert_macros.svh"

module sql_error_signature_detector
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       channel,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       detected,
    output logic [2:0] rule_code,
    input  logic       cfg_write,
    input  logic [6:0] cfg_data
);

    localparam int HISTORY_BYTES_M1 = sqlsig_pkg::HISTORY_BYTES - 1;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg;
    logic       chan_in_reg;
    logic       last_reg;

    // buffer state
    logic [7:0]                     hist_reg [HISTORY_BYTES_M1];
    logic [sqlsig_pkg::FLAGS_W-1:0] flags_reg, flags_next;
    sqlsig_pkg::bin_prog_t          prog_reg, prog_next;
    logic                           chan_reg, chan_next;
    sqlsig_pkg::seen_t              seen_reg, seen_next;
    logic [sqlsig_pkg::MASK_W-1:0]  mask_reg;

    // output register
    logic                   out_valid_reg, out_valid_next;
    sqlsig_pkg::rule_code_t code_reg, code_next;

    logic                  accept;
    logic                  out_free;
    logic                  proc_fire;
    sqlsig_pkg::window_t   window;
    sqlsig_pkg::seen_t     seen_inc;
    logic [sqlsig_pkg::FLAGS_W-1:0] hits;
    logic                  buf_chan;

    assign out_free  = !out_valid_reg || !out_stall;
    assign proc_fire = in_valid_reg && (!last_reg || out_free);
    assign in_stall  = in_valid_reg && !proc_fire;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc_fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        window[7:0] = byte_reg;
        for (int k = 1; k < sqlsig_pkg::HISTORY_BYTES; k++)
        begin
            window[8*k +: 8] = hist_reg[k-1];
        end
    end

    assign seen_inc = (seen_reg == '1) ? seen_reg : seen_reg + 1'b1;
    assign buf_chan = (seen_reg == '0) ? chan_in_reg : chan_reg;

    always_comb
    begin
        hits = '0;
        hits[sqlsig_pkg::FLAG_MYSQL] = sqlsig_pkg::text_hit(window,
            sqlsig_pkg::SIG_MYSQL, sqlsig_pkg::LEN_MYSQL, seen_inc);
        hits[sqlsig_pkg::FLAG_JDBC] = sqlsig_pkg::text_hit(window,
            sqlsig_pkg::SIG_JDBC, sqlsig_pkg::LEN_JDBC, seen_inc);
        hits[sqlsig_pkg::FLAG_NOSQL] = sqlsig_pkg::text_hit(window,
            sqlsig_pkg::SIG_NOSQL, sqlsig_pkg::LEN_NOSQL, seen_inc);
        hits[sqlsig_pkg::FLAG_PG_S] = sqlsig_pkg::text_hit(window,
            sqlsig_pkg::SIG_PG_S, sqlsig_pkg::LEN_PG_S, seen_inc);
        hits[sqlsig_pkg::FLAG_PG_V] = sqlsig_pkg::text_hit(window,
            sqlsig_pkg::SIG_PG_V, sqlsig_pkg::LEN_PG_V, seen_inc);
        hits[sqlsig_pkg::FLAG_PG_N] = sqlsig_pkg::text_hit(window,
            sqlsig_pkg::SIG_PG_N, sqlsig_pkg::LEN_PG_N, seen_inc);
        hits[sqlsig_pkg::FLAG_SQLITE] = sqlsig_pkg::text_hit(window,
            sqlsig_pkg::SIG_SQLITE, sqlsig_pkg::LEN_SQLITE, seen_inc);
        prog_next = sqlsig_pkg::bin_advance(prog_reg, byte_reg);
        hits[sqlsig_pkg::FLAG_BIN] = prog_next[sqlsig_pkg::BIN_LEN-1];
    end

    // Verdict over the flags including this byte's hits.
    logic [sqlsig_pkg::FLAGS_W-1:0] f;
    assign f = flags_reg | hits;

    always_comb
    begin
        code_next = sqlsig_pkg::RULE_NONE;
        if (!buf_chan)
        begin
            priority if (f[sqlsig_pkg::FLAG_MYSQL] && mask_reg[0])
                code_next = sqlsig_pkg::RULE_MYSQL;
            else if (f[sqlsig_pkg::FLAG_JDBC] && mask_reg[1])
                code_next = sqlsig_pkg::RULE_JDBC_TEXT;
            else if (f[sqlsig_pkg::FLAG_NOSQL] && mask_reg[2])
                code_next = sqlsig_pkg::RULE_NOSQL;
            else if (f[sqlsig_pkg::FLAG_PG_S] && f[sqlsig_pkg::FLAG_PG_V]
                     && f[sqlsig_pkg::FLAG_PG_N] && mask_reg[3])
                code_next = sqlsig_pkg::RULE_PG;
            else if (f[sqlsig_pkg::FLAG_BIN] && mask_reg[4])
                code_next = sqlsig_pkg::RULE_JDBC_BIN;
            else
                code_next = sqlsig_pkg::RULE_NONE;
        end
        else
        begin
            priority if (f[sqlsig_pkg::FLAG_SQLITE] && mask_reg[5])
                code_next = sqlsig_pkg::RULE_SQLITE;
            else if (f[sqlsig_pkg::FLAG_JDBC] && mask_reg[1])
                code_next = sqlsig_pkg::RULE_JDBC_TEXT;
            else
                code_next = sqlsig_pkg::RULE_NONE;
        end
    end

    always_comb
    begin
        flags_next = flags_reg;
        seen_next  = seen_reg;
        chan_next  = chan_reg;
        if (proc_fire)
        begin
            if (last_reg)
            begin
                flags_next = '0;
                seen_next  = '0;
                chan_next  = 1'b0;
            end
            else
            begin
                flags_next = f;
                seen_next  = seen_inc;
                chan_next  = buf_chan;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (proc_fire && last_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            flags_reg     <= '0;
            prog_reg      <= '0;
            chan_reg      <= 1'b0;
            seen_reg      <= '0;
            mask_reg      <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            flags_reg     <= flags_next;
            chan_reg      <= chan_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            if (proc_fire)
            begin
                prog_reg <= last_reg ? '0 : prog_next;
            end
            if (cfg_write)
            begin
                mask_reg <= cfg_data;
            end
        end
    end

    // Payload registers. History content older than seen_reg bytes is
    // never compared, so it needs no clearing between buffers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg    <= data_byte;
            chan_in_reg <= channel;
            last_reg    <= last_byte;
        end
        if (proc_fire)
        begin
            hist_reg[0] <= byte_reg;
            for (int k = 1; k < HISTORY_BYTES_M1; k++)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
        if (proc_fire && last_reg)
        begin
            code_reg <= code_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign rule_code = code_reg;
    assign detected  = (code_reg != sqlsig_pkg::RULE_NONE);

    `ASSERT_NEXT(a_verdict_loads, clk, rst_n, proc_fire && last_reg, out_valid)
    `ASSERT_NEXT(a_state_clears, clk, rst_n, proc_fire && last_reg,
                 (seen_reg == '0) && (flags_reg == '0) && (prog_reg == '0))
    `ASSERT_IMPL(a_last_waits, clk, rst_n,
                 in_valid_reg && last_reg && out_valid_reg && out_stall, in_stall)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                 out_valid && $stable(rule_code))
    `ASSERT_IMPL(a_progress_chain, clk, rst_n, proc_fire && !last_reg,
                 ((prog_next & ~{prog_reg[sqlsig_pkg::BIN_LEN-2:0], 1'b1}
                   & ~prog_reg) == '0))

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int PAT_LEN      = 18;

    localparam string TXT_MYSQL  = "You have an error i";
    localparam string TXT_JDBC   = "java.sql.SQLSyntaxErrorException:";
    localparam string TXT_NOSQL  = "BadValue";
    localparam string TXT_PG_S   = "SERROR";
    localparam string TXT_PG_V   = "VERROR";
    localparam string TXT_PG_N   = "or near";
    localparam string TXT_SQLITE = {"SQLITE", "_ERROR:"};

    typedef logic [7:0] byte_t;

    // sticky "seen in this buffer" bits, one per signature piece
    typedef struct packed {
        logic sqlite;
        logic bin;
        logic pg_n;
        logic pg_v;
        logic pg_s;
        logic nosql;
        logic jdbc;
        logic mysql;
    } hits_t;

    typedef struct packed {
        logic                   detected;
        sqlsig_pkg::rule_code_t code;
    } verdict_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       channel = 1'b0;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       detected;
    logic [2:0] rule_code;
    logic       cfg_write = 1'b0;
    logic [6:0] cfg_data = 7'h00;

    // scanner state mirror
    byte_t       hist [sqlsig_pkg::HISTORY_BYTES];
    hits_t       hits;
    logic [17:0] pat_prog;
    logic        buf_chan;
    logic [5:0]  buf_len;
    logic [6:0]  rule_mask;

    verdict_t    verdict_q [$];
    byte_t       frame [$];
    int          fails = 0;
    bit          steady = 1'b0;
    int          hold_ask = 0;
    int          hold_left = 0;
    int          cycle_count = 0;

    sql_error_signature_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .channel   (channel),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .detected  (detected),
        .rule_code (rule_code),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ---------------- prediction ----------------

    function automatic sqlsig_pkg::bin_elem_t pat_kind(int k);
        case (k)
            4, 8:    return sqlsig_pkg::EL_ANY;
            9, 14:   return sqlsig_pkg::EL_PRINT;
            default: return sqlsig_pkg::EL_LIT;
        endcase
    endfunction

    function automatic byte_t pat_val(int k);
        case (k)
            0:       return 8'h02;
            13:      return 8'h05;
            15, 16:  return 8'hff;
            17:      return 8'hea;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [17:0] pat_step(logic [17:0] cur, byte_t b);
        logic [17:0] nxt;
        logic [17:0] prior;
        logic        prn;
        int          k;
        prior = {cur[16:0], 1'b1};
        prn   = (b >= 8'h20) && (b < 8'h7f);
        nxt   = '0;
        for (k = 0; k < PAT_LEN; k++)
        begin
            case (pat_kind(k))
                sqlsig_pkg::EL_LIT: nxt[k] = prior[k] && (b == pat_val(k));
                sqlsig_pkg::EL_ANY: nxt[k] = prior[k];
                default:            nxt[k] = prn && (prior[k] || cur[k]);
            endcase
        end
        return nxt;
    endfunction

    // does the history end with sig (newest byte = last char)?
    function automatic logic tail_is(string sig);
        int n;
        int k;
        n = sig.len();
        if (n > sqlsig_pkg::HISTORY_BYTES || int'(buf_len) < n)
            return 1'b0;
        for (k = 0; k < n; k++)
            if (hist[k] != byte_t'(sig[n - 1 - k]))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic rule_on(sqlsig_pkg::rule_code_t r);
        return rule_mask[int'(r) - 1];
    endfunction

    function automatic void clear_buffer();
        foreach (hist[i])
            hist[i] = 8'h00;
        hits     = '0;
        pat_prog = '0;
        buf_chan = 1'b0;
        buf_len  = '0;
    endfunction

    function automatic void absorb_byte(byte_t b, logic ch, logic last);
        sqlsig_pkg::rule_code_t code;
        verdict_t               v;
        int                     k;
        if (buf_len == 0)
            buf_chan = ch;
        for (k = sqlsig_pkg::HISTORY_BYTES - 1; k > 0; k--)
            hist[k] = hist[k - 1];
        hist[0] = b;
        if (buf_len != 6'd63)
            buf_len++;

        if (tail_is(TXT_MYSQL))  hits.mysql  = 1'b1;
        if (tail_is(TXT_JDBC))   hits.jdbc   = 1'b1;
        if (tail_is(TXT_NOSQL))  hits.nosql  = 1'b1;
        if (tail_is(TXT_PG_S))   hits.pg_s   = 1'b1;
        if (tail_is(TXT_PG_V))   hits.pg_v   = 1'b1;
        if (tail_is(TXT_PG_N))   hits.pg_n   = 1'b1;
        if (tail_is(TXT_SQLITE)) hits.sqlite = 1'b1;
        pat_prog = pat_step(pat_prog, b);
        if (pat_prog[PAT_LEN - 1])
            hits.bin = 1'b1;

        if (!last)
            return;

        code = sqlsig_pkg::RULE_NONE;
        if (!buf_chan)
        begin
            if (hits.mysql && rule_on(sqlsig_pkg::RULE_MYSQL))
                code = sqlsig_pkg::RULE_MYSQL;
            else if (hits.jdbc && rule_on(sqlsig_pkg::RULE_JDBC_TEXT))
                code = sqlsig_pkg::RULE_JDBC_TEXT;
            else if (hits.nosql && rule_on(sqlsig_pkg::RULE_NOSQL))
                code = sqlsig_pkg::RULE_NOSQL;
            else if (hits.pg_s && hits.pg_v && hits.pg_n && rule_on(sqlsig_pkg::RULE_PG))
                code = sqlsig_pkg::RULE_PG;
            else if (hits.bin && rule_on(sqlsig_pkg::RULE_JDBC_BIN))
                code = sqlsig_pkg::RULE_JDBC_BIN;
        end
        else
        begin
            if (hits.sqlite && rule_on(sqlsig_pkg::RULE_SQLITE))
                code = sqlsig_pkg::RULE_SQLITE;
            else if (hits.jdbc && rule_on(sqlsig_pkg::RULE_JDBC_TEXT))
                code = sqlsig_pkg::RULE_JDBC_TEXT;
        end
        v.detected = (code != sqlsig_pkg::RULE_NONE);
        v.code     = code;
        verdict_q.push_back(v);
        clear_buffer();
    endfunction

    // ---------------- buffer builders ----------------

    function automatic void add_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            frame.push_back(byte_t'(s[i]));
    endfunction

    function automatic void add_noise(int n);
        repeat (n)
            frame.push_back(byte_t'($urandom_range(255)));
    endfunction

    function automatic void add_printable(int n);
        int pick;
        repeat (n)
        begin
            pick = $urandom_range(7);
            if (pick == 0)
                frame.push_back(8'h20);
            else if (pick == 1)
                frame.push_back(8'h7e);
            else
                frame.push_back(byte_t'($urandom_range(8'h20, 8'h7e)));
        end
    endfunction

    // binary pattern; element spoil_at (if in range) gets a breaking byte, which an any-byte element still accepts
    function automatic void add_pattern(int spoil_at);
        int k;
        for (k = 0; k < PAT_LEN; k++)
        begin
            if (k == spoil_at)
                frame.push_back(pat_kind(k) == sqlsig_pkg::EL_LIT ?
                                pat_val(k) ^ 8'h80 : 8'h7f);
            else
            begin
                case (pat_kind(k))
                    sqlsig_pkg::EL_LIT: frame.push_back(pat_val(k));
                    sqlsig_pkg::EL_ANY: frame.push_back(byte_t'($urandom_range(255)));
                    default:            add_printable($urandom_range(1, 4));
                endcase
            end
        end
    endfunction

    function automatic string pick_sig();
        case ($urandom_range(6))
            0:       return TXT_MYSQL;
            1:       return TXT_JDBC;
            2:       return TXT_NOSQL;
            3:       return TXT_PG_S;
            4:       return TXT_PG_V;
            5:       return TXT_PG_N;
            default: return TXT_SQLITE;
        endcase
    endfunction

    // one char corrupted, or cut short
    function automatic void add_near_miss(string s);
        int pos;
        int i;
        pos = $urandom_range(s.len() - 1);
        if ($urandom_range(1) == 0)
        begin
            for (i = 0; i < pos; i++)
                frame.push_back(byte_t'(s[i]));
        end
        else
        begin
            for (i = 0; i < s.len(); i++)
                frame.push_back(i == pos ? byte_t'(s[i]) ^ 8'h20
                                         : byte_t'(s[i]));
        end
    endfunction

    function automatic void build_random_frame();
        int target;
        int pick;
        frame.delete();
        target = ($urandom_range(9) == 0) ? $urandom_range(64, 100)
                                          : $urandom_range(1, 45);
        while (frame.size() < target)
        begin
            pick = $urandom_range(11);
            case (pick)
                0, 1:    add_noise($urandom_range(1, 4));
                2:       add_printable($urandom_range(1, 6));
                3, 4, 5: add_text(pick_sig());
                6:       add_pattern(-1);
                7:       add_pattern($urandom_range(PAT_LEN - 1));
                8:       add_near_miss(pick_sig());
                9:
                begin
                    add_text(TXT_PG_S);
                    add_printable($urandom_range(0, 3));
                    add_text(TXT_PG_N);
                    add_text(TXT_PG_V);
                end
                10:      add_text($urandom_range(1) ? TXT_SQLITE : TXT_JDBC);
                default: frame.push_back(8'h00);
            endcase
        end
    endfunction

    // ---------------- driving ----------------

    task automatic send_byte(byte_t b, logic ch, logic last);
        while (!steady && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        channel   <= ch;
        last_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        absorb_byte(b, ch, last);
    endtask

    // wobble: later bytes carry a random channel, which must be ignored
    task automatic send_buffer(byte_t bytes[$], logic ch, bit wobble);
        int i;
        logic c;
        for (i = 0; i < bytes.size(); i++)
        begin
            c = (i != 0 && wobble) ? logic'($urandom_range(1)) : ch;
            send_byte(bytes[i], c, i == bytes.size() - 1);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_mask(logic [6:0] m);
        drain();
        cfg_write <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        cfg_write <= 1'b0;
        rule_mask = m;
    endtask

    // ---------------- result checking ----------------

    always @(posedge clk)
    begin : take_result
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("unexpected result: detected=%0b rule_code=%0d",
                       detected, rule_code);
                fails++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (detected !== want.detected)
                begin
                    $error("detected mismatch: expected %0b, got %0b",
                           want.detected, detected);
                    fails++;
                end
                if (rule_code !== want.code)
                begin
                    $error("rule_code mismatch: expected %0d, got %0d",
                           want.code, rule_code);
                    fails++;
                end
            end
        end
    end

    // receiver side: random holds, or a long counted hold on request
    always @(posedge clk)
    begin : receiver
        if (hold_ask > 0)
        begin
            hold_left = hold_ask;
            hold_ask  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !steady && ($urandom_range(99) < 17);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------- tests ----------------

    task automatic test_each_rule();
        byte_t part [$];
        frame.delete(); add_text(TXT_MYSQL); send_buffer(frame, 1'b0, 1'b0);
        frame.delete(); add_text(TXT_JDBC); send_buffer(frame, 1'b0, 1'b0);
        frame.delete(); add_noise(5); add_text(TXT_NOSQL); send_buffer(frame, 1'b0, 1'b0);
        frame.delete(); add_text(TXT_PG_N); add_printable(3); add_text(TXT_PG_S);
        add_text(TXT_PG_V); send_buffer(frame, 1'b0, 1'b0);
        frame.delete(); add_pattern(-1); send_buffer(frame, 1'b0, 1'b0);
        frame.delete(); add_noise(2); add_text(TXT_SQLITE); send_buffer(frame, 1'b1, 1'b0);
        frame.delete(); add_text(TXT_JDBC); add_noise(3); send_buffer(frame, 1'b1, 1'b0);
        // signatures of the other channel don't count
        frame.delete(); add_text(TXT_MYSQL); add_text(TXT_NOSQL);
        send_buffer(frame, 1'b1, 1'b0);
        frame.delete(); add_text(TXT_SQLITE); send_buffer(frame, 1'b0, 1'b0);
        // postgres needs all three pieces
        frame.delete(); add_text(TXT_PG_S); add_text(TXT_PG_V);
        send_buffer(frame, 1'b0, 1'b0);
        // pattern split over two buffers never matches
        frame.delete(); add_pattern(-1);
        part = frame[0:5];
        send_buffer(part, 1'b0, 1'b0);
        part = frame[6:$];
        send_buffer(part, 1'b0, 1'b0);
        frame.delete(); frame.push_back(8'hff); send_buffer(frame, 1'b0, 1'b0);
        frame.delete(); frame.push_back(8'h00); send_buffer(frame, 1'b1, 1'b0);
    endtask

    // runs with no idling on either side
    task automatic test_priority_and_mask();
        int n;
        logic [6:0] m;
        steady = 1'b1;
        for (n = 0; n < 6; n++)
        begin
            // last mask turns off sqlite so channel 1 falls back to jdbc
            m = (n < 5) ? 7'(7'h7f << n) : 7'h1f;
            write_mask(m);
            frame.delete();
            add_pattern(-1); add_text(TXT_PG_S); add_text(TXT_PG_V); add_text(TXT_PG_N);
            add_text(TXT_NOSQL); add_text(TXT_JDBC); add_text(TXT_MYSQL);
            send_buffer(frame, 1'b0, 1'b0);
            frame.delete();
            add_text(TXT_JDBC); add_text(TXT_SQLITE);
            send_buffer(frame, 1'b1, 1'b0);
        end
        write_mask(7'h7f);
        steady = 1'b0;
    endtask

    task automatic test_edge_cases();
        // past the saturation point of the byte count
        frame.delete(); add_noise(70); add_text(TXT_MYSQL); send_buffer(frame, 1'b0, 1'b0);
        frame.delete(); add_text(TXT_MYSQL); add_noise(70); send_buffer(frame, 1'b0, 1'b0);
        frame.delete(); add_printable(66); add_pattern(-1); send_buffer(frame, 1'b0, 1'b0);
        // channel may change after the first byte
        frame.delete(); add_noise(1); add_text(TXT_SQLITE); send_buffer(frame, 1'b1, 1'b1);
        frame.delete(); add_noise(1); add_text(TXT_SQLITE); send_buffer(frame, 1'b0, 1'b1);
        // non-printable inside a printable run, or a wrong final byte, breaks the pattern
        frame.delete(); add_pattern(9); send_buffer(frame, 1'b0, 1'b0);
        frame.delete(); add_pattern(14); send_buffer(frame, 1'b0, 1'b0);
        frame.delete(); add_pattern(17); send_buffer(frame, 1'b0, 1'b0);
    endtask

    task automatic test_backpressure();
        int i;
        drain();
        steady   = 1'b1;
        hold_ask = 120;
        for (i = 0; i < 24; i++)
        begin
            frame.delete();
            if (i % 4 == 0)
                add_text(TXT_NOSQL);
            else
                add_noise($urandom_range(1, 3));
            send_buffer(frame, 1'b0, 1'b0);
        end
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        int phase;
        int sent;
        logic [6:0] m;
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       m = 7'h7f;
                2:       m = 7'h00;
                default: m = 7'($urandom_range(127));
            endcase
            write_mask(m);
            steady = (phase == 1);
            sent = 0;
            while (sent < RANDOM_BYTES / 5)
            begin
                build_random_frame();
                sent += frame.size();
                send_buffer(frame, logic'($urandom_range(1)), $urandom_range(3) == 0);
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        clear_buffer();
        rule_mask = 7'h7f;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_each_rule();
        test_priority_and_mask();
        test_edge_cases();
        test_backpressure();
        test_random_traffic();

        drain();
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
